>>> rtl/core/sdmd_pkg.sv
// ----------------------------------------------------------------------------
// Sigma-delta motion detector: shared definitions
// Field widths, register codes, reset values and the types that pass
// between the pipeline stages.
// ----------------------------------------------------------------------------
package sdmd_pkg;

   localparam int PIX_W     = 8;
   localparam int IDX_W     = 16;
   localparam int GAIN_W    = 4;
   localparam int VAR_W     = 8;
   localparam int CSR_IDX_W = 2;
   localparam int TARGET_W  = GAIN_W + PIX_W;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VAR_FLOOR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VAR_CEILING = 2'd2;

   localparam logic [GAIN_W-1:0] GAIN_RESET        = 4'd3;
   localparam logic [VAR_W-1:0]  VAR_FLOOR_RESET   = 8'd1;
   localparam logic [VAR_W-1:0]  VAR_CEILING_RESET = 8'd254;
   localparam logic [VAR_W-1:0]  VAR_MAX           = 8'd255;

   typedef struct packed {
      logic [GAIN_W-1:0] gain;
      logic [VAR_W-1:0]  var_floor;
      logic [VAR_W-1:0]  var_ceiling;
   } cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             init_frame;
   } pix_item_type;

endpackage

>>> rtl/core/sigma_delta_motion_detect_unit.sv
// ----------------------------------------------------------------------------
// Sigma-delta motion detector
// Per-pixel background mean and variance with a motion decision per pixel.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ channel (valid/ready) with their raster index and
// an init flag; one result per pixel leaves on the rsp_ channel in the same
// order. An init pixel loads the mean with the pixel and the variance with
// the floor and reports no motion.
// The pipeline has four register stages: index reduction, mean store and
// difference, variance store and clamp, output register. One pixel is taken
// every cycle while the receiver does not stall.
// Mean and variance stores each take one read and one write per cycle; the
// write of one pixel is forwarded to the next, so repeated indexes run at
// full rate too.
// Reset clears the pipeline and loads the gain, floor and ceiling with their
// defaults; the stores are not cleared and must be set by init pixels.
// When the receiver stalls the stages fill up behind the output register;
// req_ready falls only once all four hold a pixel.
// The csr_ port writes gain, variance floor and variance ceiling by index.
// Use it only while no pixel is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module sigma_delta_motion_detect_unit #(
   parameter int FRAME_PIXELS = 65536
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [sdmd_pkg::PIX_W-1:0]     req_pixel,
   input  logic [sdmd_pkg::IDX_W-1:0]     req_pixel_index,
   input  logic                           req_init_frame,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_motion,
   output logic [sdmd_pkg::PIX_W-1:0]     rsp_difference,
   output logic [sdmd_pkg::VAR_W-1:0]     rsp_variance_out,
   input  logic                           csr_write_en,
   input  logic [sdmd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sdmd_pkg::VAR_W-1:0]     csr_wdata
);
   import sdmd_pkg::*;

   localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

   cfg_type           cfg_ff;
   cfg_type           cfg_in;
   pix_item_type      req_item;

   logic              addr_valid;
   logic              addr_ready;
   pix_item_type      addr_item;
   logic [ADDR_W-1:0] addr_addr;

   logic              mean_valid;
   logic              mean_ready;
   logic [ADDR_W-1:0] mean_addr;
   logic [PIX_W-1:0]  mean_difference;
   logic              mean_init;

   always_comb begin
      req_item.pixel      = req_pixel;
      req_item.init_frame = req_init_frame;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_GAIN:        cfg_in.gain        = csr_wdata[GAIN_W-1:0];
            CSR_VAR_FLOOR:   cfg_in.var_floor   = csr_wdata;
            CSR_VAR_CEILING: cfg_in.var_ceiling = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain        <= GAIN_RESET;
         cfg_ff.var_floor   <= VAR_FLOOR_RESET;
         cfg_ff.var_ceiling <= VAR_CEILING_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sdmd_addr_stage #(
      .FRAME_PIXELS (FRAME_PIXELS),
      .ADDR_W       (ADDR_W)
   ) u_addr_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .in_index  (req_pixel_index),
      .out_valid (addr_valid),
      .out_ready (addr_ready),
      .out_item  (addr_item),
      .out_addr  (addr_addr)
   );

   sdmd_mean_stage #(
      .FRAME_PIXELS (FRAME_PIXELS),
      .ADDR_W       (ADDR_W)
   ) u_mean_stage (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (addr_valid),
      .in_ready       (addr_ready),
      .in_item        (addr_item),
      .in_addr        (addr_addr),
      .out_valid      (mean_valid),
      .out_ready      (mean_ready),
      .out_addr       (mean_addr),
      .out_difference (mean_difference),
      .out_init       (mean_init)
   );

   sdmd_var_stage #(
      .FRAME_PIXELS (FRAME_PIXELS),
      .ADDR_W       (ADDR_W)
   ) u_var_stage (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .in_valid       (mean_valid),
      .in_ready       (mean_ready),
      .in_addr        (mean_addr),
      .in_difference  (mean_difference),
      .in_init        (mean_init),
      .out_valid      (rsp_valid),
      .out_ready      (rsp_ready),
      .out_motion     (rsp_motion),
      .out_difference (rsp_difference),
      .out_variance   (rsp_variance_out)
   );

`ifndef ASSERT_OFF
   // A transfer in must land in the first stage.
   a_accept_fills_first_stage: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> addr_valid
   ) else $error("accepted pixel did not reach the address stage");

   // Back-pressure at the input can only come from a stalled result.
   a_stall_from_output: assert property (
      @(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready)
   ) else $error("input stalled without a stalled result");

   a_motion_consistent: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_motion) |-> (rsp_difference >= rsp_variance_out)
   ) else $error("motion reported with difference below variance");
`endif

endmodule

>>> rtl/core/sdmd_addr_stage.sv
// ----------------------------------------------------------------------------
// Sigma-delta motion detector: address stage
// Reduces the pixel index modulo the frame size. The quotient is found by a
// reciprocal multiply on entry and the remainder is formed from the
// registered quotient on the way out.
// ----------------------------------------------------------------------------
module sdmd_addr_stage #(
   parameter int FRAME_PIXELS = 65536,
   parameter int ADDR_W       = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  sdmd_pkg::pix_item_type     in_item,
   input  logic [sdmd_pkg::IDX_W-1:0] in_index,
   output logic                       out_valid,
   input  logic                       out_ready,
   output sdmd_pkg::pix_item_type     out_item,
   output logic [ADDR_W-1:0]          out_addr
);
   import sdmd_pkg::*;

   // With this shift the rounded-up reciprocal gives the exact quotient for
   // every index of IDX_W bits.
   localparam int SHIFT   = IDX_W + $clog2(FRAME_PIXELS);
   localparam int RECIP_W = IDX_W + 2;
   localparam int PROD_W  = IDX_W + RECIP_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(FRAME_PIXELS) - 64'd1) / 64'(FRAME_PIXELS);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

   logic               valid_ff;
   logic               valid_in;
   pix_item_type       item_ff;
   logic [IDX_W-1:0]   index_ff;
   logic [IDX_W-1:0]   quot_ff;
   logic [IDX_W-1:0]   quot_in;
   logic [PROD_W-1:0]  prod;
   logic [31:0]        quot_times_frame;
   logic [IDX_W-1:0]   remainder;
   logic               take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      prod    = PROD_W'(in_index) * PROD_W'(RECIP);
      quot_in = IDX_W'(prod >> SHIFT);
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff  <= in_item;
         index_ff <= in_index;
         quot_ff  <= quot_in;
      end
   end

   always_comb begin
      quot_times_frame = 32'(quot_ff) * 32'(FRAME_PIXELS);
      remainder        = index_ff - quot_times_frame[IDX_W-1:0];
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_addr  = ADDR_W'(remainder);

endmodule

>>> rtl/core/sdmd_mean_stage.sv
// ----------------------------------------------------------------------------
// Sigma-delta motion detector: mean stage
// Holds the background mean of every pixel. The mean is read when an item
// enters, stepped one grey level toward the pixel, and written back when the
// item moves on. The absolute difference is formed here.
// ----------------------------------------------------------------------------
module sdmd_mean_stage #(
   parameter int FRAME_PIXELS = 65536,
   parameter int ADDR_W       = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  sdmd_pkg::pix_item_type     in_item,
   input  logic [ADDR_W-1:0]          in_addr,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [ADDR_W-1:0]          out_addr,
   output logic [sdmd_pkg::PIX_W-1:0] out_difference,
   output logic                       out_init
);
   import sdmd_pkg::*;

   logic [PIX_W-1:0]  mean_mem [FRAME_PIXELS];

   logic              valid_ff;
   logic              valid_in;
   pix_item_type      item_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [PIX_W-1:0]  mean_rd_ff;
   logic              last_valid_ff;
   logic [ADDR_W-1:0] last_addr_ff;
   logic [PIX_W-1:0]  last_mean_ff;
   logic [PIX_W-1:0]  mean_old;
   logic [PIX_W-1:0]  mean_new;
   logic              in_fire;
   logic              out_fire;

   assign in_ready = !valid_ff || out_ready;
   assign in_fire  = in_valid && in_ready;
   assign out_fire = valid_ff && out_ready;

   // Only the item held here writes the mean, so the one write that can be
   // missed by the read is the one made on the same edge by the previous
   // item. The last write is kept aside and used in its place.
   always_comb begin
      if (last_valid_ff && (last_addr_ff == addr_ff)) begin
         mean_old = last_mean_ff;
      end else begin
         mean_old = mean_rd_ff;
      end
      if (item_ff.init_frame) begin
         mean_new = item_ff.pixel;
      end else if (mean_old < item_ff.pixel) begin
         mean_new = mean_old + 1'b1;
      end else if (mean_old > item_ff.pixel) begin
         mean_new = mean_old - 1'b1;
      end else begin
         mean_new = mean_old;
      end
      if (mean_new > item_ff.pixel) begin
         out_difference = mean_new - item_ff.pixel;
      end else begin
         out_difference = item_ff.pixel - mean_new;
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         last_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (out_fire) begin
            last_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         item_ff    <= in_item;
         addr_ff    <= in_addr;
         mean_rd_ff <= mean_mem[in_addr];
      end
      if (out_fire) begin
         mean_mem[addr_ff] <= mean_new;
         last_addr_ff      <= addr_ff;
         last_mean_ff      <= mean_new;
      end
   end

   assign out_valid = valid_ff;
   assign out_addr  = addr_ff;
   assign out_init  = item_ff.init_frame;

endmodule

>>> rtl/core/sdmd_var_stage.sv
// ----------------------------------------------------------------------------
// Sigma-delta motion detector: variance stage
// Holds the variance of every pixel, steps it one toward gain times the
// difference, clamps it and decides motion. The result is held in the
// output register until the receiver takes it.
// ----------------------------------------------------------------------------
module sdmd_var_stage #(
   parameter int FRAME_PIXELS = 65536,
   parameter int ADDR_W       = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sdmd_pkg::cfg_type          cfg,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [ADDR_W-1:0]          in_addr,
   input  logic [sdmd_pkg::PIX_W-1:0] in_difference,
   input  logic                       in_init,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic                       out_motion,
   output logic [sdmd_pkg::PIX_W-1:0] out_difference,
   output logic [sdmd_pkg::VAR_W-1:0] out_variance
);
   import sdmd_pkg::*;

   logic [VAR_W-1:0]    var_mem [FRAME_PIXELS];

   logic                valid_ff;
   logic                valid_in;
   logic [ADDR_W-1:0]   addr_ff;
   logic [PIX_W-1:0]    diff_ff;
   logic                init_ff;
   logic [VAR_W-1:0]    var_rd_ff;
   logic                last_valid_ff;
   logic [ADDR_W-1:0]   last_addr_ff;
   logic [VAR_W-1:0]    last_var_ff;
   logic                res_valid_ff;
   logic                res_valid_in;
   logic                motion_ff;
   logic [PIX_W-1:0]    res_diff_ff;
   logic [VAR_W-1:0]    res_var_ff;

   logic [VAR_W-1:0]    var_old;
   logic [TARGET_W-1:0] target;
   logic [TARGET_W-1:0] var_old_wide;
   logic [VAR_W:0]      var_step;
   logic [VAR_W-1:0]    var_sat;
   logic [VAR_W-1:0]    var_clamped;
   logic [VAR_W-1:0]    var_new;
   logic                motion_new;
   logic                res_ready;
   logic                in_fire;
   logic                move;

   assign res_ready = !res_valid_ff || out_ready;
   assign in_ready  = !valid_ff || res_ready;
   assign in_fire   = in_valid && in_ready;
   assign move      = valid_ff && res_ready;

   always_comb begin
      // The previous item's variance is written on the edge this item read
      // the store, so the last write stands in for the read where they match.
      if (last_valid_ff && (last_addr_ff == addr_ff)) begin
         var_old = last_var_ff;
      end else begin
         var_old = var_rd_ff;
      end
      target       = TARGET_W'(cfg.gain) * TARGET_W'(diff_ff);
      var_old_wide = TARGET_W'(var_old);
      if (var_old_wide < target) begin
         var_step = (VAR_W+1)'(var_old) + 1'b1;
      end else if (var_old_wide > target) begin
         var_step = (VAR_W+1)'(var_old) - 1'b1;
      end else begin
         var_step = (VAR_W+1)'(var_old);
      end
      if (var_step > (VAR_W+1)'(VAR_MAX)) begin
         var_sat = VAR_MAX;
      end else begin
         var_sat = var_step[VAR_W-1:0];
      end
      var_clamped = var_sat;
      if (var_clamped > cfg.var_ceiling) begin
         var_clamped = cfg.var_ceiling;
      end
      // The floor is applied last so that it wins over the ceiling.
      if (var_clamped < cfg.var_floor) begin
         var_clamped = cfg.var_floor;
      end
      var_new    = init_ff ? cfg.var_floor : var_clamped;
      motion_new = !init_ff && (diff_ff >= var_new);
      valid_in     = in_ready ? in_valid : valid_ff;
      res_valid_in = res_ready ? valid_ff : res_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         res_valid_ff  <= 1'b0;
         last_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         res_valid_ff <= res_valid_in;
         if (move) begin
            last_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         addr_ff   <= in_addr;
         diff_ff   <= in_difference;
         init_ff   <= in_init;
         var_rd_ff <= var_mem[in_addr];
      end
      if (move) begin
         var_mem[addr_ff] <= var_new;
         last_addr_ff     <= addr_ff;
         last_var_ff      <= var_new;
         motion_ff        <= motion_new;
         res_diff_ff      <= diff_ff;
         res_var_ff       <= var_new;
      end
   end

   assign out_valid      = res_valid_ff;
   assign out_motion     = motion_ff;
   assign out_difference = res_diff_ff;
   assign out_variance   = res_var_ff;

endmodule

>>> test/tb_sigma_delta_motion_detect_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the sigma-delta motion detector
// Drives pixel transfers with random gaps against a randomly stalling
// receiver. Each result is checked against typed values or a local model of
// the per-pixel mean and variance. The run steps through several gain, floor
// and ceiling settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_sigma_delta_motion_detect_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import sdmd_pkg::*;

   localparam int unsigned STALL_LIMIT  = 5000;
   localparam int unsigned PHASE_ITEMS  = 115;
   localparam int unsigned N_PHASES     = 10;
   localparam int unsigned N_DIRECTED   = 20;
   localparam int unsigned DRAIN_CYCLES = 8;
   // Index 3 is not a register; writes to it must leave the settings alone.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic             motion;
      logic [PIX_W-1:0] difference;
      logic [VAR_W-1:0] variance;
   } pixel_verdict_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [IDX_W-1:0] pixel_index;
      logic             init_frame;
      logic             typed;
      logic             motion;
      logic [PIX_W-1:0] difference;
      logic [VAR_W-1:0] variance;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_pixel;
   logic [IDX_W-1:0]     req_pixel_index;
   logic                 req_init_frame;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_motion;
   logic [PIX_W-1:0]     rsp_difference;
   logic [VAR_W-1:0]     rsp_variance_out;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [VAR_W-1:0]     csr_wdata;

   // Local copy of the block's settings and per-pixel stores.
   logic [GAIN_W-1:0] cfg_gain;
   logic [VAR_W-1:0]  cfg_floor;
   logic [VAR_W-1:0]  cfg_ceiling;
   logic [PIX_W-1:0]  mean_mem [0:65535];
   logic [VAR_W-1:0]  var_mem  [0:65535];
   bit                pixel_seen [0:65535];
   logic [IDX_W-1:0]  written_list [$];
   logic [IDX_W-1:0]  scene_pool [$];

   pixel_verdict_type expected_verdicts [$];

   int unsigned pixels_sent;
   int unsigned inits_sent;
   int unsigned verdicts_seen;
   int unsigned motion_seen;
   int unsigned error_count;
   int unsigned idle_cycles;
   bit          tx_calm;
   bit          rx_calm;

   // Expected values are typed in for inits, the extremes and a pixel at its
   // mean, under the reset settings (gain 3, floor 1, ceiling 254).
   stim_row_type directed_rows [0:N_DIRECTED-1] = '{
      '{8'd0,   16'h0000, 1'b1, 1'b1, 1'b0, 8'd0,   8'd1},
      '{8'd255, 16'hFFFF, 1'b1, 1'b1, 1'b0, 8'd0,   8'd1},
      '{8'd128, 16'h5555, 1'b1, 1'b1, 1'b0, 8'd0,   8'd1},
      '{8'd127, 16'hAAAA, 1'b1, 1'b1, 1'b0, 8'd0,   8'd1},
      '{8'd255, 16'h0000, 1'b0, 1'b1, 1'b1, 8'd254, 8'd2},
      '{8'd0,   16'hFFFF, 1'b0, 1'b1, 1'b1, 8'd254, 8'd2},
      '{8'd128, 16'h5555, 1'b0, 1'b1, 1'b0, 8'd0,   8'd1},
      '{8'd255, 16'h0000, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0},
      '{8'd255, 16'h0000, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0},
      '{8'd0,   16'h0000, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0},
      '{8'd126, 16'hAAAA, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0},
      '{8'h0F,  16'h00FF, 1'b1, 1'b1, 1'b0, 8'd0,   8'd1},
      '{8'hF0,  16'h00FF, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0},
      '{8'hAA,  16'hFF00, 1'b1, 1'b1, 1'b0, 8'd0,   8'd1},
      '{8'h55,  16'hFF00, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0},
      '{8'hAA,  16'hFF00, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0},
      '{8'd200, 16'h0000, 1'b1, 1'b1, 1'b0, 8'd0,   8'd1},
      '{8'd200, 16'h0000, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0},
      '{8'd0,   16'hFFFF, 1'b1, 1'b1, 1'b0, 8'd0,   8'd1},
      '{8'd1,   16'hFFFF, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0}
   };

   cfg_type phase_settings [0:N_PHASES-1] = '{
      '{4'd3,  8'd1,   8'd254},
      '{4'd15, 8'd1,   8'd254},
      '{4'd15, 8'd1,   8'd20},
      '{4'd0,  8'd10,  8'd200},
      '{4'd15, 8'd254, 8'd255},
      '{4'd8,  8'd200, 8'd50},
      '{4'd2,  8'd0,   8'd0},
      '{4'd15, 8'd0,   8'd255},
      '{4'd1,  8'd1,   8'd254},
      '{4'd5,  8'd30,  8'd120}
   };

   sigma_delta_motion_detect_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel        (req_pixel),
      .req_pixel_index  (req_pixel_index),
      .req_init_frame   (req_init_frame),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_motion       (rsp_motion),
      .rsp_difference   (rsp_difference),
      .rsp_variance_out (rsp_variance_out),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Updates the stored mean and variance of one pixel and returns the
   // verdict the block should give for it.
   function automatic pixel_verdict_type update_background(input logic [PIX_W-1:0] pix,
                                                           input logic [IDX_W-1:0] idx,
                                                           input logic init_frame);
      pixel_verdict_type verdict;
      int m;
      int v;
      int d;
      int target;
      if (init_frame) begin
         mean_mem[idx] = pix;
         var_mem[idx]  = cfg_floor;
         if (!pixel_seen[idx]) begin
            pixel_seen[idx] = 1'b1;
            written_list.push_back(idx);
         end
         verdict.motion     = 1'b0;
         verdict.difference = '0;
         verdict.variance   = cfg_floor;
         return verdict;
      end
      m = int'(mean_mem[idx]);
      if (m < int'(pix))
         m = m + 1;
      else if (m > int'(pix))
         m = m - 1;
      d = (m > int'(pix)) ? m - int'(pix) : int'(pix) - m;
      v = int'(var_mem[idx]);
      target = int'(cfg_gain) * d;
      if (v < target)
         v = v + 1;
      else if (v > target)
         v = v - 1;
      // The step saturates at 255; the floor is applied last and wins.
      if (v > 255)
         v = 255;
      if (v > int'(cfg_ceiling))
         v = int'(cfg_ceiling);
      if (v < int'(cfg_floor))
         v = int'(cfg_floor);
      mean_mem[idx] = m[PIX_W-1:0];
      var_mem[idx]  = v[VAR_W-1:0];
      verdict.motion     = (d >= v);
      verdict.difference = d[PIX_W-1:0];
      verdict.variance   = v[VAR_W-1:0];
      return verdict;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return $urandom_range(1, 3);
      if (r < 95)
         return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   // Presents one pixel and returns at the edge of its transfer. Valid is
   // only lowered when a gap goes in front of the pixel.
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [IDX_W-1:0] idx,
                             input logic init_frame, input logic typed,
                             input pixel_verdict_type typed_verdict);
      int unsigned gap;
      pixel_verdict_type verdict;
      gap = (tx_calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel       <= pix;
      req_pixel_index <= idx;
      req_init_frame  <= init_frame;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      verdict = update_background(pix, idx, init_frame);
      expected_verdicts.push_back(typed ? typed_verdict : verdict);
      pixels_sent++;
      if (init_frame)
         inits_sent++;
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_verdicts.size() > 0);
   endtask

   // Writes all three registers back to back; only called with nothing in
   // flight. The gain write carries random junk in the unused upper bits.
   task automatic apply_settings(input cfg_type s, input bit touch_spare);
      logic [VAR_W-GAIN_W-1:0] junk;
      junk = (VAR_W-GAIN_W)'($urandom_range(0, 15));
      csr_write_en <= 1'b1;
      csr_index    <= CSR_GAIN;
      csr_wdata    <= {junk, s.gain};
      @(posedge clock);
      csr_index <= CSR_VAR_FLOOR;
      csr_wdata <= s.var_floor;
      @(posedge clock);
      csr_index <= CSR_VAR_CEILING;
      csr_wdata <= s.var_ceiling;
      @(posedge clock);
      if (touch_spare) begin
         csr_index <= CSR_SPARE;
         csr_wdata <= VAR_W'($urandom_range(0, 255));
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      cfg_gain    = s.gain;
      cfg_floor   = s.var_floor;
      cfg_ceiling = s.var_ceiling;
   endtask

   // A small scene of pixels is initialised and then updated many times, so
   // that the variances get far enough from the floor to reach the clamps.
   // A minority of transfers re-initialise pixels or touch older ones.
   task automatic run_phase(input int unsigned count);
      int unsigned n;
      int unsigned i;
      int unsigned r;
      int unsigned s;
      int unsigned sent;
      int p;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] last_idx;
      scene_pool.delete();
      n = $urandom_range(3, 8);
      for (i = 0; i < n; i++) begin
         r = $urandom_range(0, 9);
         idx = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : IDX_W'($urandom_range(0, 65535));
         scene_pool.push_back(idx);
         send_pixel(PIX_W'($urandom_range(0, 255)), idx, 1'b1, 1'b0, '0);
      end
      sent = n;
      last_idx = scene_pool[0];
      while (sent < count) begin
         r = $urandom_range(0, 99);
         if (r < 6) begin
            idx = scene_pool[$urandom_range(0, n - 1)];
            send_pixel(PIX_W'($urandom_range(0, 255)), idx, 1'b1, 1'b0, '0);
         end else if (r < 9) begin
            idx = IDX_W'($urandom_range(0, 65535));
            send_pixel(PIX_W'($urandom_range(0, 255)), idx, 1'b1, 1'b0, '0);
         end else begin
            // Only pixels that have seen an init are ever updated.
            if (r < 14)
               idx = written_list[$urandom_range(0, written_list.size() - 1)];
            else if ($urandom_range(0, 2) == 0)
               idx = last_idx;
            else
               idx = scene_pool[$urandom_range(0, n - 1)];
            s = $urandom_range(0, 9);
            if (s < 5) begin
               p = int'(mean_mem[idx]) + int'($urandom_range(0, 6)) - 3;
               if (p < 0)
                  p = 0;
               if (p > 255)
                  p = 255;
            end else if (s < 8) begin
               p = $urandom_range(0, 255);
            end else begin
               p = (s == 8) ? 0 : 255;
            end
            send_pixel(p[PIX_W-1:0], idx, 1'b0, 1'b0, '0);
         end
         last_idx = idx;
         sent++;
      end
   endtask

   // Receiver: accepts freely for stretches and otherwise stalls at random.
   initial begin : receiver
      int unsigned hold;
      hold = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 4) == 0)
               hold = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      pixel_verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         verdicts_seen++;
         if (rsp_motion)
            motion_seen++;
         if (expected_verdicts.size() == 0) begin
            $error("result transfer with nothing expected: motion %0d, %s %0d, %s %0d",
                   rsp_motion, "difference", rsp_difference, "variance", rsp_variance_out);
            error_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_motion !== want.motion) begin
               $error("motion: expected %0d, got %0d", want.motion, rsp_motion);
               error_count++;
            end
            if (rsp_difference !== want.difference) begin
               $error("difference: expected %0d, got %0d", want.difference, rsp_difference);
               error_count++;
            end
            if (rsp_variance_out !== want.variance) begin
               $error("variance_out: expected %0d, got %0d", want.variance, rsp_variance_out);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      wait (idle_cycles >= STALL_LIMIT);
      $display("tb_sigma_delta_motion_detect_unit: done, errors");
      $finish;
   end

   initial begin : stimulus
      int unsigned k;
      pixel_verdict_type typed_verdict;
      pixels_sent     = 0;
      inits_sent      = 0;
      tx_calm         = 1'b0;
      rx_calm         = 1'b0;
      cfg_gain        = GAIN_RESET;
      cfg_floor       = VAR_FLOOR_RESET;
      cfg_ceiling     = VAR_CEILING_RESET;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_pixel       <= '0;
      req_pixel_index <= '0;
      req_init_frame  <= 1'b0;
      csr_write_en    <= 1'b0;
      csr_index       <= CSR_GAIN;
      csr_wdata       <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < N_DIRECTED; k++) begin
         typed_verdict.motion     = directed_rows[k].motion;
         typed_verdict.difference = directed_rows[k].difference;
         typed_verdict.variance   = directed_rows[k].variance;
         send_pixel(directed_rows[k].pixel, directed_rows[k].pixel_index,
                    directed_rows[k].init_frame, directed_rows[k].typed, typed_verdict);
      end
      drain_pipeline();

      // Each setting is applied with the pipeline empty, so the sender has
      // waited for every outstanding result before it.
      for (k = 0; k < N_PHASES; k++) begin
         apply_settings(phase_settings[k], (k % 3) == 0);
         tx_calm = (k == 1) || ($urandom_range(0, 4) == 0);
         rx_calm = (k == 1) || ($urandom_range(0, 4) == 0);
         run_phase(PHASE_ITEMS);
         drain_pipeline();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run covered %0d pixel transfers, %0d of them inits, under %0d register settings.",
               pixels_sent, inits_sent, N_PHASES + 1);
      $display("%0d results checked, %0d reporting motion, %0d mismatches.",
               verdicts_seen, motion_seen, error_count);
      if (error_count == 0)
         $display("tb_sigma_delta_motion_detect_unit: done, clean");
      else
         $display("tb_sigma_delta_motion_detect_unit: done, errors");
      $finish;
   end

endmodule
